// ----- sv/tit_pkg.sv -----
// Types and constants shared by the trajectory interpolation table.
`timescale 1ns / 1ps
package tit_pkg;

    localparam int TimeBits = 17;
    localparam int FracBits = 16;
    localparam logic [TimeBits-1:0] TIME_ONE = 17'h10000;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_ORDER = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [3:0]          vertex;
        logic [TimeBits-1:0] time_req;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         entry_index;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic [TimeBits-1:0] tstamp;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic signed [31:0]  z;
    } entry_t;

endpackage

// ----- sv/tit_in_if.sv -----
// Input channel: valid/ready with one request item.
`timescale 1ns / 1ps
interface tit_in_if
    import tit_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tit_out_if.sv -----
// Output channel: valid/ready with one result item.
`timescale 1ns / 1ps
interface tit_out_if
    import tit_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tit_div.sv -----
// Serial restoring divider for the 16-bit interpolation fraction.
`timescale 1ns / 1ps
module tit_div
    import tit_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TimeBits-1:0] num,
    input  logic [TimeBits-1:0] den,
    output logic                done,
    output logic [FracBits-1:0] quo
);

    logic                busy_reg;
    logic                done_reg;
    logic [3:0]          cnt_reg;
    logic [TimeBits-1:0] rem_reg;
    logic [FracBits-1:0] quo_reg;
    logic [TimeBits:0]   shifted;
    logic                ge;
    logic [TimeBits:0]   diff;

    assign shifted = {rem_reg, 1'b0};
    assign ge      = shifted >= {1'b0, den};
    assign diff    = shifted - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[TimeBits-1:0] : shifted[TimeBits-1:0];
            quo_reg <= {quo_reg[FracBits-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- sv/trajectory_interp_table.sv -----
// Trajectory interpolation table: per-vertex timed positions, append and query.
// Appends are checked for a full list and for time order. Queries binary-search the vertex
// list, with at most ceil(log2(n+1)) search steps, and interpolate where the time falls
// between two entries, using the serial divider and a multiply and add per axis.
// One item at a time: the next transfer is taken once the result of the last one is posted.
// After reset a clearing pass zeroes the count memory; no input then.
`timescale 1ns / 1ps
module trajectory_interp_table
    import tit_pkg::*;
#(
    parameter int VERTICES           = 16,
    parameter int ENTRIES_PER_VERTEX = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    tit_in_if.sink         req,
    tit_out_if.source      rsp
);

    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int EW = $clog2(ENTRIES_PER_VERTEX);
    localparam int CW = $clog2(ENTRIES_PER_VERTEX + 1);
    localparam int AW = VW + EW;
    localparam int Depth = VERTICES << EW;

    typedef enum logic [12:0] {
        ST_CLEAR = 13'h0001,
        ST_IDLE  = 13'h0002,
        ST_CNT   = 13'h0004,
        ST_APCHK = 13'h0008,
        ST_SRD   = 13'h0010,
        ST_SCMP  = 13'h0020,
        ST_PREVW = 13'h0040,
        ST_NEXTW = 13'h0080,
        ST_DIV   = 13'h0100,
        ST_MUL   = 13'h0200,
        ST_ADD   = 13'h0400,
        ST_FIN   = 13'h0800,
        ST_WAIT  = 13'h1000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]       count_mem [VERTICES];
    entry_t              entry_mem [Depth];

    logic [CW-1:0]       cnt_q_reg;
    entry_t              ent_q_reg;

    logic [VW-1:0]       clr_reg;
    logic                op_reg;
    logic                vok_reg;
    logic [VW-1:0]       v_reg;
    logic [TimeBits-1:0] t_reg;
    logic signed [31:0]  ap_reg [3];
    logic [CW-1:0]       n_reg;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic [TimeBits-1:0] tp_reg;
    logic signed [31:0]  pp_reg [3];
    logic signed [31:0]  pn_reg [3];
    logic                az_reg;
    logic [FracBits-1:0] alpha_reg;
    logic [1:0]          axis_reg;
    logic signed [49:0]  prod_reg;
    logic signed [31:0]  res_reg [3];
    logic [CW-1:0]       idx_reg;
    logic [1:0]          status_reg;
    out_item_t           out_reg;
    logic                out_valid_reg;

    logic                accept;
    logic                vert_ok;
    logic [VW+3:0]       vext;
    logic [TimeBits-1:0] t_sat;
    logic [CW-1:0]       cnt_dec;
    logic [CW-1:0]       mid;
    logic [CW-1:0]       prev;
    logic                rd_en;
    logic [EW-1:0]       rd_idx;
    logic [AW-1:0]       rd_addr;
    logic                app_ok;
    logic                out_free;
    logic                div_done;
    logic [FracBits-1:0] div_quo;
    logic [TimeBits-1:0] div_num;
    logic [TimeBits-1:0] div_den;
    logic signed [32:0]  diff;
    logic signed [33:0]  shf;
    logic signed [33:0]  acc;
    logic [CW+5:0]       idx_ext;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign vert_ok  = 32'(req.data.vertex) < VERTICES;
    assign vext     = {{VW{1'b0}}, req.data.vertex};
    assign t_sat    = (req.data.time_req > TIME_ONE) ? TIME_ONE : req.data.time_req;
    assign cnt_dec  = cnt_q_reg - CW'(1);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign prev     = (lo_reg == '0) ? '0 : lo_reg - CW'(1);
    assign app_ok   = (n_reg == '0) || !(t_reg < ent_q_reg.tstamp);
    assign out_free = !out_valid_reg || rsp.ready;
    assign div_num  = t_reg - tp_reg;
    assign div_den  = ent_q_reg.tstamp - tp_reg;
    assign diff     = 33'(pn_reg[axis_reg]) - 33'(pp_reg[axis_reg]);
    assign shf      = 34'(prod_reg >>> FracBits);
    assign acc      = 34'(pp_reg[axis_reg]) + shf;
    assign idx_ext  = {6'b0, idx_reg};

    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = '0;
        priority case (1'b1)
            (state_reg == ST_CNT):
            begin
                rd_en  = vok_reg;
                rd_idx = cnt_dec[EW-1:0];
            end
            (state_reg == ST_SRD):
            begin
                rd_en  = 1'b1;
                rd_idx = (lo_reg < hi_reg) ? mid[EW-1:0] : prev[EW-1:0];
            end
            (state_reg == ST_PREVW):
            begin
                rd_en  = 1'b1;
                rd_idx = lo_reg[EW-1:0];
            end
            default:
            begin
                rd_en  = 1'b0;
                rd_idx = '0;
            end
        endcase
    end

    assign rd_addr = {v_reg, rd_idx};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == VW'(VERTICES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_CNT;
            ST_CNT:
            begin
                if (op_reg == OP_APPEND)
                    state_next = (!vok_reg || cnt_q_reg >= CW'(ENTRIES_PER_VERTEX))
                                 ? ST_FIN : ST_APCHK;
                else
                    state_next = (!vok_reg || cnt_q_reg == '0) ? ST_FIN : ST_SRD;
            end
            ST_APCHK: state_next = ST_FIN;
            ST_SRD:   state_next = (lo_reg < hi_reg) ? ST_SCMP : ST_PREVW;
            ST_SCMP:  state_next = ST_SRD;
            ST_PREVW: state_next = (lo_reg == '0 || lo_reg >= n_reg) ? ST_FIN : ST_NEXTW;
            ST_NEXTW: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = (axis_reg == 2'd2) ? ST_FIN : ST_MUL;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            ST_WAIT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + VW'(1);
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // count memory: clearing pass, lookup on transfer, update on append
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            count_mem[clr_reg] <= '0;
        else if (state_reg == ST_APCHK && app_ok)
            count_mem[v_reg] <= n_reg + CW'(1);
        if (accept)
            cnt_q_reg <= count_mem[vext[VW-1:0]];
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_APCHK && app_ok)
            entry_mem[{v_reg, n_reg[EW-1:0]}] <= '{t_reg, ap_reg[0], ap_reg[1], ap_reg[2]};
        if (rd_en)
            ent_q_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.data.op;
            vok_reg   <= vert_ok;
            v_reg     <= vext[VW-1:0];
            t_reg     <= t_sat;
            ap_reg[0] <= req.data.pos_x;
            ap_reg[1] <= req.data.pos_y;
            ap_reg[2] <= req.data.pos_z;
        end
        unique case (state_reg)
            ST_CNT:
            begin
                n_reg      <= cnt_q_reg;
                lo_reg     <= '0;
                hi_reg     <= cnt_q_reg;
                res_reg[0] <= '0;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
                idx_reg    <= '0;
                if (op_reg == OP_APPEND)
                    status_reg <= STATUS_FULL;
                else
                    status_reg <= (!vok_reg || cnt_q_reg == '0) ? STATUS_EMPTY : STATUS_OK;
            end
            ST_APCHK:
            begin
                status_reg <= app_ok ? STATUS_OK : STATUS_ORDER;
                idx_reg    <= app_ok ? n_reg : '0;
            end
            ST_SCMP:
            begin
                if (!(ent_q_reg.tstamp > t_reg))
                    lo_reg <= mid + CW'(1);
                else
                    hi_reg <= mid;
            end
            ST_PREVW:
            begin
                tp_reg     <= ent_q_reg.tstamp;
                pp_reg[0]  <= ent_q_reg.x;
                pp_reg[1]  <= ent_q_reg.y;
                pp_reg[2]  <= ent_q_reg.z;
                res_reg[0] <= ent_q_reg.x;
                res_reg[1] <= ent_q_reg.y;
                res_reg[2] <= ent_q_reg.z;
                idx_reg    <= prev;
            end
            ST_NEXTW:
            begin
                pn_reg[0] <= ent_q_reg.x;
                pn_reg[1] <= ent_q_reg.y;
                pn_reg[2] <= ent_q_reg.z;
                az_reg    <= (div_den == '0) || (t_reg < tp_reg);
                axis_reg  <= '0;
            end
            ST_DIV:
            begin
                if (div_done)
                    alpha_reg <= az_reg ? '0 : div_quo;
            end
            ST_MUL:
            begin
                prod_reg <= diff * $signed({1'b0, alpha_reg});
            end
            ST_ADD:
            begin
                res_reg[axis_reg] <= acc[31:0];
                axis_reg          <= axis_reg + 2'd1;
            end
            ST_FIN:
            begin
                if (out_free)
                    out_reg <= '{res_reg[0], res_reg[1], res_reg[2],
                                 idx_ext[5:0], status_reg};
            end
            default:
            begin
            end
        endcase
    end

    tit_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_NEXTW),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APCHK && app_ok) |-> (n_reg < CW'(ENTRIES_PER_VERTEX)))
        else $error("append past end of list");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCMP) |-> (lo_reg < hi_reg && hi_reg <= n_reg))
        else $error("binary search window out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish state");

    a_div_only_interp: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule

// ----- test/trajectory_interp_table_checker.sv -----
// Checker for the trajectory interpolation table: predicts each result and compares it.
`timescale 1ns / 1ps
module trajectory_interp_table_checker
    import tit_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    tit_in_if.sink  req_mon,
    tit_out_if.sink rsp_mon,
    output int      fail_count,
    output int      pending
);
    localparam int NV = 16;
    localparam int NE = 64;

    logic [6:0]          list_len [NV];
    logic [TimeBits-1:0] stamp_mem [NV*NE];
    logic signed [31:0]  point_mem [NV*NE][3];
    out_item_t           expected_q [$];

    function automatic out_item_t compute_result(in_item_t it);
        out_item_t r;
        logic [TimeBits-1:0] t;
        int v, n, base, lo, hi, mid, prev, nxt;
        longint unsigned dt, alpha;
        longint s;
        logic signed [31:0] res [3];
        r = '0;
        v = it.vertex;
        t = (it.time_req > TIME_ONE) ? TIME_ONE : it.time_req;
        n = list_len[v];
        base = v * NE;
        if (it.op == OP_APPEND) begin
            if (n >= NE) begin
                r.status = STATUS_FULL;
            end else if (n > 0 && t < stamp_mem[base+n-1]) begin
                r.status = STATUS_ORDER;
            end else begin
                stamp_mem[base+n] = t;
                point_mem[base+n][0] = it.pos_x;
                point_mem[base+n][1] = it.pos_y;
                point_mem[base+n][2] = it.pos_z;
                list_len[v] = n + 1;
                r.entry_index = n[5:0];
                r.status = STATUS_OK;
            end
            return r;
        end
        if (n == 0) begin
            r.status = STATUS_EMPTY;
            return r;
        end
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (stamp_mem[base+mid] <= t) lo = mid + 1;
            else hi = mid;
        end
        nxt = lo;
        prev = (nxt == 0) ? 0 : nxt - 1;
        for (int k = 0; k < 3; k++) res[k] = point_mem[base+prev][k];
        if (nxt != 0 && nxt < n) begin
            dt = stamp_mem[base+nxt] - stamp_mem[base+prev];
            alpha = 0;
            if (dt != 0 && t >= stamp_mem[base+prev])
                alpha = (64'(t - stamp_mem[base+prev]) << FracBits) / dt;
            if (alpha > 65535) alpha = 65535;
            for (int k = 0; k < 3; k++) begin
                s = longint'(point_mem[base+prev][k]) * longint'(65536 - alpha)
                  + longint'(point_mem[base+nxt][k]) * longint'(alpha);
                res[k] = 32'(s >>> FracBits);
            end
        end
        r.out_x = res[0];
        r.out_y = res[1];
        r.out_z = res[2];
        r.entry_index = prev[5:0];
        r.status = STATUS_OK;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        out_item_t got;
        out_item_t pred;
        if (!rst_n) begin
            for (int i = 0; i < NV; i++) list_len[i] = 0;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (req_mon.valid && req_mon.ready) begin
                pred = compute_result(req_mon.data);
                expected_q.insert(expected_q.size(), pred);
            end
            if (rsp_mon.valid && rsp_mon.ready) begin
                got = rsp_mon.data;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fail_count <= fail_count + 1;
                        if (got.out_x !== want.out_x)
                            $error("out_x expected %0d got %0d", want.out_x, got.out_x);
                        if (got.out_y !== want.out_y)
                            $error("out_y expected %0d got %0d", want.out_y, got.out_y);
                        if (got.out_z !== want.out_z)
                            $error("out_z expected %0d got %0d", want.out_z, got.out_z);
                        if (got.entry_index !== want.entry_index)
                            $error("entry_index expected %0d got %0d",
                                   want.entry_index, got.entry_index);
                        if (got.status !== want.status)
                            $error("status expected %0d got %0d", want.status, got.status);
                    end
                end
            end
        end
    end
endmodule

// ----- test/trajectory_interp_table_tb.sv -----
// Testbench top for the trajectory interpolation table: stimulus, flow control, verdict.
`timescale 1ns / 1ps
module trajectory_interp_table_tb;
    import tit_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   recv_hold;
    logic [TimeBits-1:0] last_stamp [16];

    tit_in_if  req ();
    tit_out_if rsp ();

    trajectory_interp_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    trajectory_interp_table_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req.sink),
        .rsp_mon    (rsp.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) rsp.ready <= 1'b0;
        else rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // ready only changes at rising edges, so it is sampled at the falling edge before
    task automatic send_item(input in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        @(negedge clk);
        while (!req.ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_op(input logic op, input logic [3:0] v, input logic [TimeBits-1:0] t,
                           input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic signed [31:0] z);
        in_item_t it;
        it.op = op;
        it.vertex = v;
        it.time_req = t;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        send_item(it);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        logic [3:0] v;
        logic [TimeBits-1:0] t;
        int pick;
        for (int i = 0; i < count; i++) begin
            v = 4'($urandom_range(15));
            pick = $urandom_range(99);
            if (pick < 45) begin
                t = last_stamp[v] + 17'($urandom_range(4000));
                if ($urandom_range(19) == 0) t = 17'($urandom);
                if (t > TIME_ONE) t = TIME_ONE;
                last_stamp[v] = t;
                send_op(OP_APPEND, v, t, $urandom, $urandom, $urandom);
            end else if (pick < 52) begin
                send_op(OP_APPEND, v, 17'($urandom), $urandom, $urandom, $urandom);
            end else begin
                t = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
                send_op(OP_QUERY, v, t, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 16; i++) last_stamp[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        // directed: empty list, extremes, interpolation, clamps, order error, full list
        send_op(OP_QUERY, 4'd0, 17'd0, 0, 0, 0);
        send_op(OP_APPEND, 4'd0, 17'd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
        send_op(OP_APPEND, 4'd0, 17'd50, 1, 2, 3);
        send_op(OP_QUERY, 4'd0, 17'd0, 0, 0, 0);
        send_op(OP_APPEND, 4'd0, 17'd100, -1, 1, 5);
        send_op(OP_APPEND, 4'd0, 17'd40000, 32'sh80000000, 32'sh7FFFFFFF, -65536);
        send_op(OP_QUERY, 4'd0, 17'd100, 0, 0, 0);
        send_op(OP_QUERY, 4'd0, 17'd20000, 0, 0, 0);
        send_op(OP_QUERY, 4'd0, 17'h1FFFF, 0, 0, 0);
        send_op(OP_APPEND, 4'd0, 17'h1FFFF, 7, 8, 9);
        send_op(OP_QUERY, 4'd0, 17'd65535, -1, -1, -1);
        send_op(OP_QUERY, 4'd15, 17'd5, 0, 0, 0);
        for (int i = 0; i < 66; i++)
            send_op(OP_APPEND, 4'd15, 17'(i * 1000), $urandom, $urandom, $urandom);
        send_op(OP_QUERY, 4'd15, 17'd31500, 0, 0, 0);
        last_stamp[15] = TIME_ONE;
        last_stamp[0] = TIME_ONE;
        wait_drained();

        random_phase(400);
        send_idle_pct = 63;
        random_phase(300);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 63;
        random_phase(300);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        random_phase(300);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            random_phase(150);
        join
        wait_drained();
        random_phase(150);

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
